// ----- hw/rtl/cube_face_projection_bounds_core_assert.svh -----
// Assertion macros for the cube face bounds core
`ifndef CUBE_FACE_PROJECTION_BOUNDS_CORE_ASSERT_SVH
`define CUBE_FACE_PROJECTION_BOUNDS_CORE_ASSERT_SVH
`define CFPB_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CFPB_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/cfpb_pkg.sv -----
// ----------------------------------------------------------------------------
// cfpb_pkg
// Shared types and constants of the cube face bounds core.
// ----------------------------------------------------------------------------
package cfpb_pkg;
    localparam int MAX_VERTS = 64;
    localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CW = $clog2(MAX_VERTS + 1);
    localparam logic signed [32:0] BOUND_INIT = 33'sd655294464;
    localparam logic [47:0] QUOT_SAT = 48'd2147418112;
    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    typedef struct packed {
        logic clear;
        logic store;
        logic accum;
        logic set_ovf;
        logic pick_face;
        logic load_vert;
        logic div_start;
        logic div_sel_t;
        logic upd;
        logic emit;
        logic close;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic skip;
        logic full;
        logic last_idx;
        logic empty;
    } t_sts;
endpackage

// ----- hw/rtl/cfpb_div.sv -----
// ----------------------------------------------------------------------------
// cfpb_div
// Radix-2 restoring divider, 48-bit dividend by 33-bit divisor.
// ----------------------------------------------------------------------------
module cfpb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quot
);
    logic [47:0] r_q, n_q;
    logic [33:0] r_rem, n_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [33:0] sh;

    always_comb begin
        sh = {r_rem[32:0], r_q[47]};
        n_q = {r_q[46:0], 1'b0};
        n_rem = sh;
        if (sh >= {1'b0, r_den}) begin
            n_rem = sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd47;
            end else if (r_busy) begin
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ----- hw/rtl/cfpb_datapath.sv -----
// ----------------------------------------------------------------------------
// cfpb_datapath
// Vertex store, sums, face pick, projection and face bounds.
// ----------------------------------------------------------------------------
module cfpb_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cfpb_pkg::t_cmd       i_cmd,
    output cfpb_pkg::t_sts       o_sts,
    input  logic signed [31:0]   i_vert_x,
    input  logic signed [31:0]   i_vert_y,
    input  logic signed [31:0]   i_vert_z,
    input  logic [9:0]           i_min_depth,
    output logic [2:0]           o_face,
    output logic signed [30:0]   o_s_low,
    output logic signed [30:0]   o_t_low,
    output logic signed [30:0]   o_s_high,
    output logic signed [30:0]   o_t_high,
    output logic                 o_overflow
);
    import cfpb_pkg::*;

    logic [95:0] r_mem [MAX_VERTS];
    logic [95:0] r_rd;
    logic signed [38:0] r_sx, r_sy, r_sz;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_idx;
    logic r_ovf;
    logic [2:0] r_face;
    logic signed [32:0] r_bmins [6];
    logic signed [32:0] r_bmint [6];
    logic signed [32:0] r_bmaxs [6];
    logic signed [32:0] r_bmaxt [6];
    logic signed [32:0] r_s, r_t, r_num_s, r_num_t, r_dep;
    logic signed [32:0] vx, vy, vz, ns, nt, dd, num;
    logic [38:0] ax, ay, az;
    logic [2:0] fsel;
    logic [47:0] quot;
    logic div_done;
    logic signed [32:0] qs;

    function automatic logic signed [32:0] neg33(input logic signed [32:0] v);
        neg33 = -v;
    endfunction

    function automatic logic [38:0] abs39(input logic signed [38:0] v);
        abs39 = v[38] ? 39'(-v) : 39'(v);
    endfunction

    function automatic logic signed [30:0] clamp31(input logic signed [32:0] v);
        if (v > BOUND_INIT) clamp31 = 31'(BOUND_INIT);
        else if (v < -BOUND_INIT) clamp31 = 31'(-BOUND_INIT);
        else clamp31 = v[30:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_mem[r_cnt[AW-1:0]] <= {i_vert_x, i_vert_y, i_vert_z};
        r_rd <= r_mem[r_idx];
    end

    always_comb begin
        ax = abs39(r_sx);
        ay = abs39(r_sy);
        az = abs39(r_sz);
        if (ax > ay && ax > az) fsel = r_sx[38] ? FACE_NX : FACE_PX;
        else if (ay > az && ay > ax) fsel = r_sy[38] ? FACE_NY : FACE_PY;
        else fsel = r_sz[38] ? FACE_NZ : FACE_PZ;
        vx = 33'(signed'(r_rd[95:64]));
        vy = 33'(signed'(r_rd[63:32]));
        vz = 33'(signed'(r_rd[31:0]));
        unique case (r_face)
            FACE_PX: begin ns = neg33(vy); nt = vz; dd = vx; end
            FACE_NX: begin ns = vy; nt = vz; dd = neg33(vx); end
            FACE_PY: begin ns = vx; nt = vz; dd = vy; end
            FACE_NY: begin ns = neg33(vx); nt = vz; dd = neg33(vy); end
            FACE_PZ: begin ns = neg33(vy); nt = neg33(vx); dd = vz; end
            default: begin ns = neg33(vy); nt = vx; dd = neg33(vz); end
        endcase
        num = i_cmd.div_sel_t ? r_num_t : r_num_s;
        if (quot > QUOT_SAT) qs = 33'(QUOT_SAT);
        else qs = 33'(quot);
    end

    cfpb_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num({15'd0, num[32] ? 33'(-num) : num} << 16),
        .i_den(r_dep), .o_done(div_done), .o_quot(quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0; r_sy <= '0; r_sz <= '0;
            r_cnt <= '0; r_ovf <= 1'b0; r_idx <= '0; r_face <= FACE_PZ;
            for (int i = 0; i < 6; i++) begin
                r_bmins[i] <= BOUND_INIT; r_bmint[i] <= BOUND_INIT;
                r_bmaxs[i] <= -BOUND_INIT; r_bmaxt[i] <= -BOUND_INIT;
            end
        end else begin
            if (i_cmd.clear) begin
                for (int i = 0; i < 6; i++) begin
                    r_bmins[i] <= BOUND_INIT; r_bmint[i] <= BOUND_INIT;
                    r_bmaxs[i] <= -BOUND_INIT; r_bmaxt[i] <= -BOUND_INIT;
                end
            end
            if (i_cmd.accum) begin
                r_sx <= r_sx + 39'(i_vert_x);
                r_sy <= r_sy + 39'(i_vert_y);
                r_sz <= r_sz + 39'(i_vert_z);
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.set_ovf) r_ovf <= 1'b1;
            if (i_cmd.pick_face) begin
                r_face <= fsel;
                r_idx <= '0;
            end
            if (i_cmd.load_vert) begin
                r_num_s <= ns; r_num_t <= nt; r_dep <= dd;
            end
            if (div_done) begin
                if (i_cmd.div_sel_t) r_t <= num[32] ? neg33(qs) : qs;
                else r_s <= num[32] ? neg33(qs) : qs;
            end
            if (i_cmd.upd) begin
                if (r_s < r_bmins[r_face]) r_bmins[r_face] <= r_s;
                if (r_t < r_bmint[r_face]) r_bmint[r_face] <= r_t;
                if (r_s > r_bmaxs[r_face]) r_bmaxs[r_face] <= r_s;
                if (r_t > r_bmaxt[r_face]) r_bmaxt[r_face] <= r_t;
            end
            if (i_cmd.upd || (i_cmd.load_vert && o_sts.skip))
                r_idx <= r_idx + AW'(1);
            if (i_cmd.close) begin
                r_sx <= '0; r_sy <= '0; r_sz <= '0;
                r_cnt <= '0; r_ovf <= 1'b0;
            end
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.skip = (dd <= $signed({23'd0, i_min_depth}));
    assign o_sts.full = (r_cnt == CW'(MAX_VERTS));
    assign o_sts.last_idx = (CW'(r_idx) + CW'(1) >= r_cnt);
    assign o_sts.empty = (r_cnt == '0);
    assign o_face = r_face;
    assign o_s_low = clamp31(r_bmins[r_face]);
    assign o_t_low = clamp31(r_bmint[r_face]);
    assign o_s_high = clamp31(r_bmaxs[r_face]);
    assign o_t_high = clamp31(r_bmaxt[r_face]);
    assign o_overflow = r_ovf;
endmodule

// ----- hw/rtl/cfpb_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfpb_ctrl
// Sequencer: accepts vertices, then walks stored vertices through the divider.
// ----------------------------------------------------------------------------
module cfpb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last_vertex,
    input  logic           i_clear_first,
    input  cfpb_pkg::t_sts i_sts,
    output cfpb_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_done
);
    import cfpb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FACE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DIVS = 3'd4;
    localparam logic [2:0] S_DIVT = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0] r_st, n_st;
    logic r_go, n_go;

    always_comb begin
        o_cmd = '0;
        n_st = r_st;
        n_go = 1'b0;
        unique case (r_st)
            S_IDLE: if (i_start) begin
                o_cmd.clear = i_clear_first;
                o_cmd.store = !i_sts.full;
                o_cmd.accum = !i_sts.full;
                o_cmd.set_ovf = i_sts.full;
                if (i_last_vertex) n_st = S_FACE;
            end
            S_FACE: begin
                o_cmd.pick_face = 1'b1;
                n_st = i_sts.empty ? S_EMIT : S_READ;
            end
            S_READ: n_st = S_LOAD;
            S_LOAD: begin
                o_cmd.load_vert = 1'b1;
                if (i_sts.skip) n_st = i_sts.last_idx ? S_EMIT : S_READ;
                else begin
                    n_st = S_DIVS;
                    n_go = 1'b1;
                end
            end
            S_DIVS: begin
                o_cmd.div_start = r_go;
                if (i_sts.div_done) begin
                    n_st = S_DIVT;
                    n_go = 1'b1;
                end
            end
            S_DIVT: begin
                o_cmd.div_sel_t = 1'b1;
                o_cmd.div_start = r_go;
                if (i_sts.div_done) n_st = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_st = i_sts.last_idx ? S_EMIT : S_READ;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.close = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_go <= 1'b0;
        end else begin
            r_st <= n_st;
            r_go <= n_go;
        end
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_done = (r_st == S_EMIT);
endmodule

// ----- hw/rtl/cube_face_projection_bounds_core.sv -----
// ----------------------------------------------------------------------------
// cube_face_projection_bounds_core
// Cube face selection and projected s/t bounds of one polygon.
// Busy: a vertex that is not last is taken without raising busy; a last vertex
// holds busy while each stored vertex is projected (two serial 48-step divisions
// by depth) or skipped without division; the result strobe is the last busy cycle.
// Throughput: one vertex per cycle within a polygon; the receiver cannot stall.
// Reset: synchronous active low; clears sums, count, bounds and min_depth.
// ----------------------------------------------------------------------------
module cube_face_projection_bounds_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_vert_x,
    input  logic signed [31:0] i_vert_y,
    input  logic signed [31:0] i_vert_z,
    input  logic               i_last_vertex,
    input  logic               i_clear_first,
    output logic               o_valid,
    output logic [2:0]         o_face,
    output logic signed [30:0] o_s_low,
    output logic signed [30:0] o_t_low,
    output logic signed [30:0] o_s_high,
    output logic signed [30:0] o_t_high,
    output logic               o_overflow,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import cfpb_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [9:0] r_min_depth;
    logic done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_min_depth <= '0;
        else if (psel && penable && pwrite && paddr == 2'd0) r_min_depth <= pwdata[9:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {22'd0, r_min_depth} : 32'd0;

    cfpb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_last_vertex(i_last_vertex), .i_clear_first(i_clear_first),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy), .o_done(done)
    );

    cfpb_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_vert_x(i_vert_x), .i_vert_y(i_vert_y), .i_vert_z(i_vert_z),
        .i_min_depth(r_min_depth), .o_face(o_face),
        .o_s_low(o_s_low), .o_t_low(o_t_low), .o_s_high(o_s_high),
        .o_t_high(o_t_high), .o_overflow(o_overflow)
    );

    assign o_valid = done;
endmodule

// ----- hw/rtl/cfpb_checker.sv -----
// ----------------------------------------------------------------------------
// cfpb_checker
// Port-level checks of the cube face bounds core.
// ----------------------------------------------------------------------------
`include "cube_face_projection_bounds_core_assert.svh"
module cfpb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_last_vertex,
    input logic        o_valid,
    input logic [2:0]  o_face,
    input logic        pready
);
    `CFPB_ASSERT_IMPL(a_face_range, i_clk, i_rst_n, o_valid, o_face <= 3'd5)
    `CFPB_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, start && !busy && i_last_vertex, busy)
    `CFPB_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `CFPB_ASSERT_IMPL(a_ready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind cube_face_projection_bounds_core cfpb_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_last_vertex(i_last_vertex), .o_valid(o_valid), .o_face(o_face), .pready(pready)
);

// ----- dv/cube_face_projection_bounds_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_face_projection_bounds_core_tb
// Sends polygons vertex by vertex, predicts the chosen cube face and its
// projected s/t bounds, and checks every result strobe against the prediction.
// ----------------------------------------------------------------------------
module cube_face_projection_bounds_core_tb;
    import cfpb_pkg::*;

    localparam longint BND = 655294464;
    localparam longint QSAT = 2147418112;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_vert_x;
    logic signed [31:0] i_vert_y;
    logic signed [31:0] i_vert_z;
    logic               i_last_vertex;
    logic               i_clear_first;
    logic               o_valid;
    logic [2:0]         o_face;
    logic signed [30:0] o_s_low;
    logic signed [30:0] o_t_low;
    logic signed [30:0] o_s_high;
    logic signed [30:0] o_t_high;
    logic               o_overflow;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    typedef struct {
        logic [2:0]  face;
        logic [30:0] s_low;
        logic [30:0] t_low;
        logic [30:0] s_high;
        logic [30:0] t_high;
        logic        overflow;
    } bounds_t;

    bounds_t bounds_q[$];
    int      errors;
    int      send_idle;

    // predictor state
    longint  p_min_depth;
    longint  vx[MAX_VERTS];
    longint  vy[MAX_VERTS];
    longint  vz[MAX_VERTS];
    longint  sx, sy, sz;
    int      vcnt;
    bit      povf;
    longint  mn_s[6], mn_t[6], mx_s[6], mx_t[6];

    int face_tab[6][3] = '{'{-2, 3, 1}, '{2, 3, -1}, '{1, 3, 2}, '{-1, 3, -2},
                           '{-2, -1, 3}, '{-2, 1, -3}};

    cube_face_projection_bounds_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #300ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint coord(int code, int i);
        int     k;
        longint v;
        k = code < 0 ? -code : code;
        v = (k == 1) ? vx[i] : (k == 2) ? vy[i] : vz[i];
        return code < 0 ? -v : v;
    endfunction

    function automatic longint proj_div(longint num, longint den);
        longint q;
        q = (absl(num) << 16) / den;
        if (q > QSAT) q = QSAT;
        return num < 0 ? -q : q;
    endfunction

    function automatic logic [30:0] clamp31(longint v);
        if (v > BND) v = BND;
        if (v < -BND) v = -BND;
        return v[30:0];
    endfunction

    function automatic void reset_bounds();
        for (int f = 0; f < 6; f++) begin
            mn_s[f] = BND;
            mn_t[f] = BND;
            mx_s[f] = -BND;
            mx_t[f] = -BND;
        end
    endfunction

    function automatic void predict_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z, bit last, bit clr);
        longint  ax, ay, az, d, s, t;
        int      f;
        bounds_t r;
        if (clr) reset_bounds();
        if (vcnt < MAX_VERTS) begin
            vx[vcnt] = x;
            vy[vcnt] = y;
            vz[vcnt] = z;
            sx += x;
            sy += y;
            sz += z;
            vcnt++;
        end else begin
            povf = 1;
        end
        if (!last) return;
        ax = absl(sx);
        ay = absl(sy);
        az = absl(sz);
        if (ax > ay && ax > az) f = sx < 0 ? FACE_NX : FACE_PX;
        else if (ay > az && ay > ax) f = sy < 0 ? FACE_NY : FACE_PY;
        else f = sz < 0 ? FACE_NZ : FACE_PZ;
        for (int i = 0; i < vcnt; i++) begin
            d = coord(face_tab[f][2], i);
            if (d > p_min_depth) begin
                s = proj_div(coord(face_tab[f][0], i), d);
                t = proj_div(coord(face_tab[f][1], i), d);
                if (s < mn_s[f]) mn_s[f] = s;
                if (t < mn_t[f]) mn_t[f] = t;
                if (s > mx_s[f]) mx_s[f] = s;
                if (t > mx_t[f]) mx_t[f] = t;
            end
        end
        r.face = f;
        r.s_low = clamp31(mn_s[f]);
        r.t_low = clamp31(mn_t[f]);
        r.s_high = clamp31(mx_s[f]);
        r.t_high = clamp31(mx_t[f]);
        r.overflow = povf;
        bounds_q.push_back(r);
        sx = 0;
        sy = 0;
        sz = 0;
        vcnt = 0;
        povf = 0;
    endfunction

    always @(posedge i_clk) begin
        bounds_t e;
        if (i_rst_n && o_valid) begin
            if (bounds_q.size() == 0) begin
                $error("result strobe with no request pending");
                errors++;
            end else begin
                e = bounds_q.pop_front();
                if (o_face !== e.face) begin
                    $error("face exp %0d got %0d", e.face, o_face); errors++;
                end
                if (o_s_low !== e.s_low) begin
                    $error("s_low exp %h got %h", e.s_low, o_s_low); errors++;
                end
                if (o_t_low !== e.t_low) begin
                    $error("t_low exp %h got %h", e.t_low, o_t_low); errors++;
                end
                if (o_s_high !== e.s_high) begin
                    $error("s_high exp %h got %h", e.s_high, o_s_high); errors++;
                end
                if (o_t_high !== e.t_high) begin
                    $error("t_high exp %h got %h", e.t_high, o_t_high); errors++;
                end
                if (o_overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, o_overflow); errors++;
                end
            end
        end
    end

    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, bit last, bit clr);
        while ($urandom_range(99) < send_idle) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_vert_x <= x;
        i_vert_y <= y;
        i_vert_z <= z;
        i_last_vertex <= last;
        i_clear_first <= clr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_vertex(x, y, z, last, clr);
    endtask

    task automatic wait_idle();
        int n;
        n = 0;
        start <= 1'b0;
        while (bounds_q.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_min_depth(logic [9:0] v);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {22'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        p_min_depth = v;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(4095) - 2048;
            2: return {{8{1'b0}}, 24'($urandom)};
            3: return -$signed({8'd0, 24'($urandom)});
            default: return $urandom_range(1 << 20);
        endcase
    endfunction

    task automatic test_directed();
        // single vertex along each axis, both signs
        send_vertex(32'sd2560, 32'sd256, -32'sd512, 1, 1);
        send_vertex(-32'sd2560, 32'sd256, 32'sd512, 1, 0);
        send_vertex(32'sd100, 32'sd5000, -32'sd7, 1, 0);
        send_vertex(32'sd100, -32'sd5000, 32'sd7, 1, 0);
        send_vertex(32'sd300, -32'sd40, 32'sd9000, 1, 0);
        send_vertex(32'sd300, 32'sd40, -32'sd9000, 1, 0);
        // ties go to z
        send_vertex(32'sd1000, 32'sd1000, 32'sd1000, 1, 1);
        send_vertex(32'sd1000, 32'sd1000, 32'sd0, 1, 0);
        // extremes, saturating quotient
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'sd1, 1, 1);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1, 0);
        // zero vertex, depth not above min_depth
        send_vertex(32'sd0, 32'sd0, 32'sd0, 1, 1);
        // polygon of three, clear on a middle vertex
        send_vertex(32'sd10, 32'sd20, 32'sd5000, 0, 0);
        send_vertex(-32'sd300, 32'sd70, 32'sd4000, 0, 1);
        send_vertex(32'sd900, -32'sd600, 32'sd4500, 1, 0);
        // too many vertices, the dropped one also last
        for (int i = 0; i <= MAX_VERTS; i++)
            send_vertex(rand_coord(), rand_coord(), 32'sd100000 + i, i == MAX_VERTS, 0);
        for (int i = 0; i < MAX_VERTS + 3; i++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), i == MAX_VERTS + 2, 1);
    endtask

    task automatic test_random(int n_items);
        int cnt, len;
        cnt = 0;
        while (cnt < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(MAX_VERTS + 4, 30) :
                  $urandom_range(8, 1);
            for (int i = 0; i < len; i++) begin
                send_vertex(rand_coord(), rand_coord(), rand_coord(), i == len - 1,
                            $urandom_range(7) == 0);
                cnt++;
            end
        end
    endtask

    initial begin
        errors = 0;
        send_idle = 0;
        start = 1'b0;
        i_vert_x = '0;
        i_vert_y = '0;
        i_vert_z = '0;
        i_last_vertex = 1'b0;
        i_clear_first = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        p_min_depth = 0;
        sx = 0;
        sy = 0;
        sz = 0;
        vcnt = 0;
        povf = 0;
        reset_bounds();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_min_depth(10'd1023);
        test_directed();
        write_min_depth(10'd0);
        test_random(165);
        send_idle = 59;
        write_min_depth(10'($urandom_range(1023)));
        test_random(165);
        send_idle = 12;
        write_min_depth(10'd1023);
        test_random(160);
        send_idle = 0;
        write_min_depth(10'($urandom_range(255)));
        test_random(165);

        wait_idle();
        if (bounds_q.size() == 0 && errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- cube_face_projection_bounds_core.f -----
+incdir+hw/rtl
hw/rtl/cfpb_pkg.sv
hw/rtl/cfpb_div.sv
hw/rtl/cfpb_datapath.sv
hw/rtl/cfpb_ctrl.sv
hw/rtl/cube_face_projection_bounds_core.sv
hw/rtl/cfpb_checker.sv
dv/cube_face_projection_bounds_core_tb.sv
